[sv/itbd_pkg.sv]
// ----------------------------------------------------------------------------
// itbd_pkg: shared types and constants for the integer to base digits unit
// Configuration bundle, register indexes, sign characters, symbol lookup.
// ----------------------------------------------------------------------------
package itbd_pkg;

  // Alphabet geometry
  localparam int unsigned ALPHA_SLOTS = 16;
  localparam int unsigned SYM_W       = 8;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned BASE_W      = 5;
  localparam int unsigned WORD_W      = 64;

  // Quotient bits resolved per division cycle
  localparam int unsigned CHUNK_BITS  = 8;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_HIGH = 2'd2;

  // Sign characters
  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

  typedef struct packed {
    logic [BASE_W-1:0] base_count;
    logic [WORD_W-1:0] alphabet_high;
    logic [WORD_W-1:0] alphabet_low;
  } itbd_cfg_t;

  // Pick symbol byte idx from the configured alphabet
  function automatic logic [SYM_W-1:0] symbol_at(input itbd_cfg_t cfg,
                                                 input logic [DIGIT_W-1:0] idx);
    logic [2*WORD_W-1:0] all_syms;
    all_syms = {cfg.alphabet_high, cfg.alphabet_low};
    return all_syms[{idx, 3'b000} +: SYM_W];
  endfunction

endpackage

[sv/itbd_front.sv]
// ----------------------------------------------------------------------------
// itbd_front: input stage of the integer to base digits unit
// Accepts a value, checks the alphabet, splits sign and magnitude, and
// forwards good jobs to the job queue. Jobs with a bad alphabet are dropped.
// ----------------------------------------------------------------------------
module itbd_front #(
  parameter int unsigned MAX_BASE   = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  itbd_pkg::itbd_cfg_t     cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [VALUE_BITS-1:0]   in_value_i,
  output logic                    push_o,
  output logic [VALUE_BITS:0]     push_data_o,   // {negative, magnitude}
  input  logic                    push_ready_i
);
  import itbd_pkg::*;

  logic                  hold_valid_r, hold_valid_nxt;
  logic                  hold_ok_r;
  logic                  hold_neg_r;
  logic [VALUE_BITS-1:0] hold_mag_r;

  logic                  alpha_ok;
  logic                  in_neg;
  logic [VALUE_BITS-1:0] in_mag;
  logic                  hold_done;
  logic                  accept;

  // Check the alphabet: radix in range, no sign character, no repeats
  always_comb begin
    logic [SYM_W-1:0] syms [ALPHA_SLOTS];
    logic             bad;
    bad = 1'b0;
    for (int i = 0; i < ALPHA_SLOTS; i++) begin
      syms[i] = symbol_at(cfg_i, DIGIT_W'(i));
    end
    for (int i = 0; i < ALPHA_SLOTS; i++) begin
      if (BASE_W'(i) < cfg_i.base_count) begin
        if (syms[i] == SYM_PLUS || syms[i] == SYM_MINUS) begin
          bad = 1'b1;
        end
        for (int j = i + 1; j < ALPHA_SLOTS; j++) begin
          if (BASE_W'(j) < cfg_i.base_count && syms[j] == syms[i]) begin
            bad = 1'b1;
          end
        end
      end
    end
    alpha_ok = !bad && (cfg_i.base_count >= BASE_W'(2))
               && (cfg_i.base_count <= BASE_W'(MAX_BASE));
  end

  // Split sign and magnitude; the most negative value maps onto itself
  assign in_neg = in_value_i[VALUE_BITS-1];
  assign in_mag = in_neg ? (~in_value_i + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : in_value_i;

  // Drop bad jobs at once, otherwise wait for queue space
  assign hold_done  = hold_valid_r && (!hold_ok_r || push_ready_i);
  assign in_ready_o = !hold_valid_r || hold_done;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = hold_valid_r && hold_ok_r && push_ready_i;
  assign push_data_o = {hold_neg_r, hold_mag_r};

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (accept) begin
      hold_valid_nxt = 1'b1;
    end else if (hold_done) begin
      hold_valid_nxt = 1'b0;
    end
  end

  // Hold the classified beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
    if (accept) begin
      hold_ok_r  <= alpha_ok;
      hold_neg_r <= in_neg;
      hold_mag_r <= in_mag;
    end
  end

endmodule

[sv/itbd_queue.sv]
// ----------------------------------------------------------------------------
// itbd_queue: two-entry job queue
// Decouples the input stage from the digit engine.
// ----------------------------------------------------------------------------
module itbd_queue #(
  parameter int unsigned DATA_W = 33
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              push_ready_o,
  output logic              pop_valid_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] pop_data_o
);

  localparam int unsigned DEPTH = 2;

  logic [DATA_W-1:0] slots_r [DEPTH];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;

  assign push_ready_o = (count_r != 2'(DEPTH));
  assign pop_valid_o  = (count_r != 2'd0);
  assign pop_data_o   = slots_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_i;
    rd_ptr_nxt = rd_ptr_r ^ pop_i;
    count_nxt  = count_r + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push_i) begin
      slots_r[wr_ptr_r] <= push_data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_i && count_r == 2'(DEPTH)))
    else $error("job queue written while full");
`endif

endmodule

[sv/itbd_back.sv]
// ----------------------------------------------------------------------------
// itbd_back: digit engine of the integer to base digits unit
// Divides the magnitude by the radix one byte of quotient per cycle, keeps
// the digits in a small store, then emits sign and digits top first.
// ----------------------------------------------------------------------------
module itbd_back #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  itbd_pkg::itbd_cfg_t    cfg_i,
  input  logic                   pop_valid_i,
  output logic                   pop_o,
  input  logic [VALUE_BITS:0]    pop_data_i,   // {negative, magnitude}
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [7:0]             out_symbol_o,
  output logic                   out_last_o
);
  import itbd_pkg::*;

  localparam int unsigned STEPS  = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int unsigned WORK_W = STEPS * CHUNK_BITS;
  localparam int unsigned STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int unsigned CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int unsigned ADDR_W = $clog2(VALUE_BITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [WORK_W-1:0]   work_r, work_nxt;
  logic [DIGIT_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                neg_r, neg_nxt;
  logic [ADDR_W-1:0]   idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]    out_sym_r, out_sym_nxt;
  logic                out_last_r, out_last_nxt;

  logic [DIGIT_W-1:0]  digit_mem [VALUE_BITS];
  logic [DIGIT_W-1:0]  mem_q_r;
  logic                mem_we;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;

  logic [DIGIT_W-1:0]  chunk_rem;
  logic [CHUNK_BITS-1:0] chunk_quot;
  logic [WORK_W-1:0]   work_shifted;
  logic                out_free;
  logic [ADDR_W-1:0]   top_addr;

  // Long division of the next byte by the radix
  always_comb begin
    logic [BASE_W-1:0] r;
    r = {1'b0, rem_r};
    chunk_quot = '0;
    for (int b = 0; b < CHUNK_BITS; b++) begin
      r = {r[DIGIT_W-1:0], work_r[WORK_W-1-b]};
      if (r >= cfg_i.base_count) begin
        r = r - cfg_i.base_count;
        chunk_quot[CHUNK_BITS-1-b] = 1'b1;
      end
    end
    chunk_rem = r[DIGIT_W-1:0];
  end

  assign work_shifted = (work_r << CHUNK_BITS) | WORK_W'(chunk_quot);
  assign out_free     = !out_valid_r || out_ready_i;
  assign top_addr     = ADDR_W'(cnt_r - CNT_W'(1));
  assign pop_o        = (state_r == ST_IDLE) && pop_valid_i;

  assign out_valid_o  = out_valid_r;
  assign out_symbol_o = out_sym_r;
  assign out_last_o   = out_last_r;

  // Sequencer: take job, divide, emit sign, emit digits
  always_comb begin
    state_nxt     = state_r;
    work_nxt      = work_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready_i;
    out_sym_nxt   = out_sym_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = top_addr;
    unique case (state_r)
      ST_IDLE: begin
        if (pop_valid_i) begin
          work_nxt  = WORK_W'(pop_data_i[VALUE_BITS-1:0]);
          neg_nxt   = pop_data_i[VALUE_BITS];
          rem_nxt   = '0;
          step_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        work_nxt = work_shifted;
        if (step_r == STEP_W'(STEPS - 1)) begin
          // Digit complete: store it, restart on the quotient
          mem_we   = 1'b1;
          rem_nxt  = '0;
          step_nxt = '0;
          cnt_nxt  = cnt_r + CNT_W'(1);
          if (work_shifted == '0) begin
            state_nxt = ST_SIGN;
          end
        end else begin
          rem_nxt  = chunk_rem;
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_SIGN: begin
        if (!neg_r || out_free) begin
          if (neg_r) begin
            out_valid_nxt = 1'b1;
            out_sym_nxt   = SYM_MINUS;
            out_last_nxt  = 1'b0;
          end
          mem_re    = 1'b1;
          mem_raddr = top_addr;
          idx_nxt   = top_addr;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = symbol_at(cfg_i, mem_q_r);
          out_last_nxt  = (idx_r == '0);
          if (idx_r != '0) begin
            mem_re    = 1'b1;
            mem_raddr = idx_r - ADDR_W'(1);
            idx_nxt   = idx_r - ADDR_W'(1);
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and the output beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    work_r     <= work_nxt;
    rem_r      <= rem_nxt;
    neg_r      <= neg_nxt;
    idx_r      <= idx_nxt;
    out_sym_r  <= out_sym_nxt;
    out_last_r <= out_last_nxt;
  end

  // Digit store, least significant digit at address zero
  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_mem[cnt_r[ADDR_W-1:0]] <= chunk_rem;
    end
    if (mem_re) begin
      mem_q_r <= digit_mem[mem_raddr];
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(VALUE_BITS))
    else $error("digit count beyond store depth");
  a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> {1'b0, rem_r} < cfg_i.base_count)
    else $error("partial remainder not below radix");
  a_last_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_free && idx_r == '0) |=> state_r == ST_IDLE)
    else $error("engine busy after final digit");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop_o |=> state_r == ST_DIV)
    else $error("job popped without starting division");
`endif

endmodule

[sv/integer_to_base_digits_unit.sv]
// ----------------------------------------------------------------------------
// integer_to_base_digits_unit: signed integer to radix symbol stream
// Per value: the front hold register and the queue lie between the accepting edge
// and the digit engine, then each digit is found by the radix divider, one quotient
// byte per cycle, then comes the sign slot, then one beat per digit. A value may
// have D digits, D up to 32.
// Reset (rst_n low, synchronous) empties the queue and clears the control and
// configuration registers; the digit store needs no clearing pass.
// ----------------------------------------------------------------------------
module integer_to_base_digits_unit #(
  parameter int unsigned MAX_BASE   = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] in_tdata,   // [VALUE_BITS-1:0] value
  // result stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [7:0]                            out_tdata,  // [7:0] symbol
  output logic                                  out_tlast,
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [itbd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [itbd_pkg::WORD_W-1:0]           cfg_data
);
  import itbd_pkg::*;

  itbd_cfg_t cfg_r;

  logic                  q_push;
  logic [VALUE_BITS:0]   q_push_data;
  logic                  q_push_ready;
  logic                  q_pop_valid;
  logic                  q_pop;
  logic [VALUE_BITS:0]   q_pop_data;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BASE_COUNT:    cfg_r.base_count    <= cfg_data[BASE_W-1:0];
        REG_ALPHABET_LOW:  cfg_r.alphabet_low  <= cfg_data;
        REG_ALPHABET_HIGH: cfg_r.alphabet_high <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  itbd_front #(
    .MAX_BASE   (MAX_BASE),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_i        (cfg_r),
    .in_valid_i   (in_tvalid),
    .in_ready_o   (in_tready),
    .in_value_i   (in_tdata[VALUE_BITS-1:0]),
    .push_o       (q_push),
    .push_data_o  (q_push_data),
    .push_ready_i (q_push_ready)
  );

  itbd_queue #(
    .DATA_W (VALUE_BITS + 1)
  ) u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_i       (q_push),
    .push_data_i  (q_push_data),
    .push_ready_o (q_push_ready),
    .pop_valid_o  (q_pop_valid),
    .pop_i        (q_pop),
    .pop_data_o   (q_pop_data)
  );

  itbd_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_i        (cfg_r),
    .pop_valid_i  (q_pop_valid),
    .pop_o        (q_pop),
    .pop_data_i   (q_pop_data),
    .out_valid_o  (out_tvalid),
    .out_ready_i  (out_tready),
    .out_symbol_o (out_tdata),
    .out_last_o   (out_tlast)
  );

endmodule
